// ----- rtl/scps_pkg.sv -----
// ----------------------------------------------------------------------------
// scps_pkg
// shared types, codes and constants of the scsi command phase sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package scps_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_SELECT      = 3'd1,
    ACT_DMA         = 3'd2,
    ACT_CMDCOMPLETE = 3'd3,
    ACT_MSGACCEPT   = 3'd4,
    ACT_NOP         = 3'd5,
    ACT_RESET       = 3'd6
  } action_t;

  localparam logic OP_START = 1'b0;

  // command status high byte
  localparam logic [7:0] HI_SELECT  = 8'h00;
  localparam logic [7:0] HI_DATA    = 8'h41;
  localparam logic [7:0] HI_CMDCPL  = 8'h46;

  // step and interrupt codes after select
  localparam logic [10:0] CODE_SEL_DONE = 11'h020;
  localparam logic [10:0] CODE_NO_SEL   = 11'h218;
  localparam logic [10:0] CODE_CMD_FAIL = 11'h318;
  localparam logic [10:0] CODE_DATA     = 11'h418;

  localparam logic [15:0] STAT_NO_SEL   = 16'h1000;
  localparam logic [15:0] STAT_DATA     = 16'h4100;
  localparam logic [15:0] STAT_CMDCPL   = 16'h4600;
  localparam logic [7:0]  STAT_MSG_HI   = 8'h60;
  localparam logic [7:0]  STAT_FAIL_OFS = 8'h30;

  localparam logic [2:0] PHASE_STATUS = 3'd3;
  localparam int         BUS_RESET_BIT = 7;

  localparam logic [3:0] DMA_DRAIN_TYPE = 4'd8;
  localparam logic [3:0] DMA_PACK_TYPE  = 4'd9;

  typedef struct packed {
    logic        read_dir;
    logic [2:0]  target_id;
    logic [4:0]  cmd_length;
    logic [15:0] data_length;
    logic [2:0]  bus_phase;
    logic [2:0]  seq_step;
    logic [7:0]  intr_flags;
    logic [4:0]  fifo_count;
    logic [7:0]  status_byte;
    logic [15:0] residual_count;
  } item_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] cmd_status;
    logic        dir_read;
    logic [4:0]  cmd_bytes;
    logic [15:0] data_bytes;
    logic [15:0] moved_bytes;
  } seq_state_t;

  typedef struct packed {
    logic [15:0] command_status;
    action_t     action;
    logic [2:0]  select_target;
    logic        dma_to_memory;
    logic        drain_dma;
    logic        wait_pack_empty;
    logic [15:0] transferred_bytes;
    logic        done_res;
    logic        bad_event;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/scps_in_stage.sv -----
// ----------------------------------------------------------------------------
// scps_in_stage
// input register: takes one word per cycle while the take from the core does not stall it, and unpacks its fields
// ----------------------------------------------------------------------------
`default_nettype none

module scps_in_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic                           s_tuser,   // operation
  input  wire logic [scps_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                           take,
  output      logic                           valid,
  output      logic                           op,
  output      scps_pkg::item_t                item
);
  import scps_pkg::*;

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op                  <= s_tuser;
      item.read_dir       <= s_tdata[0];
      item.target_id      <= s_tdata[3:1];
      item.cmd_length     <= s_tdata[8:4];
      item.data_length    <= s_tdata[24:9];
      item.bus_phase      <= s_tdata[27:25];
      item.seq_step       <= s_tdata[30:28];
      item.intr_flags     <= s_tdata[38:31];
      item.fifo_count     <= s_tdata[43:39];
      item.status_byte    <= s_tdata[51:44];
      item.residual_count <= s_tdata[67:52];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scps_decide.sv -----
// ----------------------------------------------------------------------------
// scps_decide
// phase decision: next sequencer state and result for one word
// ----------------------------------------------------------------------------
`default_nettype none

module scps_decide (
  input  wire logic                 op,
  input  wire scps_pkg::item_t      item,
  input  wire scps_pkg::seq_state_t st,
  input  wire logic [3:0]           dma_type,
  output      scps_pkg::seq_state_t st_next,
  output      scps_pkg::result_t    res
);
  import scps_pkg::*;

  logic [10:0] code;
  logic [7:0]  hi;
  logic [7:0]  fail_hi;
  logic        to_data_end;
  logic        done;

  assign code    = {item.seq_step, item.intr_flags};
  assign hi      = st.cmd_status[15:8];
  assign fail_hi = STAT_FAIL_OFS + {3'b000, st.cmd_bytes} - {3'b000, item.fifo_count};

  always_comb begin
    st_next     = st;
    res         = '0;
    res.action  = ACT_NONE;
    to_data_end = 1'b0;
    done        = 1'b0;
    if (op == OP_START) begin
      st_next.dir_read    = item.read_dir;
      st_next.cmd_bytes   = item.cmd_length;
      st_next.data_bytes  = item.data_length;
      st_next.moved_bytes = '0;
      st_next.cmd_status  = '0;
      st_next.busy        = 1'b1;
      res.select_target   = item.target_id;
      res.action          = ACT_SELECT;
    end else begin
      if (!st.busy || item.intr_flags[BUS_RESET_BIT]) begin
        res.action = ACT_NOP;
        done       = 1'b1;
      end else if (hi == HI_SELECT) begin
        case (code)
          CODE_SEL_DONE: begin
            done = 1'b1;
          end
          CODE_NO_SEL: begin
            st_next.cmd_status = STAT_NO_SEL;
            res.bad_event      = 1'b1;
            res.action         = ACT_RESET;
            done               = 1'b1;
          end
          CODE_CMD_FAIL: begin
            st_next.cmd_status = {fail_hi, 8'h00};
            res.bad_event      = 1'b1;
            res.action         = ACT_RESET;
            done               = 1'b1;
          end
          CODE_DATA: begin
            st_next.cmd_status = STAT_DATA;
            if (item.bus_phase == {2'b00, st.dir_read}) begin
              res.action        = ACT_DMA;
              res.dma_to_memory = st.dir_read;
            end else if (item.bus_phase != PHASE_STATUS) begin
              res.bad_event = 1'b1;
              done          = 1'b1;
            end else begin
              to_data_end = 1'b1;
            end
          end
          default: begin
            res.bad_event = 1'b1;
            res.action    = ACT_RESET;
            done          = 1'b1;
          end
        endcase
      end else if (hi == HI_DATA) begin
        to_data_end = 1'b1;
      end else if (hi == HI_CMDCPL) begin
        st_next.cmd_status = {STAT_MSG_HI, item.status_byte};
        res.action         = ACT_MSGACCEPT;
      end else begin
        done = 1'b1;
      end

      if (to_data_end) begin
        st_next.cmd_status  = STAT_CMDCPL;
        st_next.moved_bytes = st.data_bytes - item.residual_count;
        if (item.bus_phase != PHASE_STATUS) begin
          res.bad_event = 1'b1;
          done          = 1'b1;
        end else begin
          if (st.dir_read) begin
            res.drain_dma       = (dma_type == DMA_DRAIN_TYPE);
            res.wait_pack_empty = (dma_type == DMA_DRAIN_TYPE) ||
                                  (dma_type == DMA_PACK_TYPE);
          end
          res.action = ACT_CMDCOMPLETE;
        end
      end
      if (done) begin
        st_next.busy = 1'b0;
      end
    end
    res.done_res          = done;
    res.command_status    = st_next.cmd_status;
    res.transferred_bytes = st_next.moved_bytes;
  end

endmodule

`default_nettype wire

// ----- rtl/scsi_command_phase_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// scsi_command_phase_sequencer_core
// sequences one scsi command through select, data, status and message phases
// ----------------------------------------------------------------------------
// an accepted input word is registered in the input stage, then its result in the output register
// throughput: one word per cycle while a stalled output register does not hold off the state update
// an output register decouples the sides, a stalled result holds one word
// reset: synchronous, clears sequencer state, dma type and both valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module scsi_command_phase_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [3:0]                      cfg_data,  // dma_type
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic                            s_tuser,   // operation
  // read_dir, target_id, cmd_length, data_length, bus_phase, seq_step,
  // intr_flags, fifo_count, status_byte, residual_count, zero pad
  input  wire logic [scps_pkg::IN_DATA_W-1:0]  s_tdata,
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // command_status, action, select_target, dma_to_memory, drain_dma,
  // wait_pack_empty, transferred_bytes, done_res, bad_event, zero pad
  output      logic [scps_pkg::OUT_DATA_W-1:0] m_tdata
);
  import scps_pkg::*;

  logic       dma_type;
  logic [3:0] dma_type_reg;
  logic       in_valid;
  logic       in_op;
  item_t      in_item;
  logic       adv;
  seq_state_t st;
  seq_state_t st_next;
  result_t    res;
  result_t    out;

  assign cfg_ready = 1'b1;
  assign dma_type  = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dma_type_reg <= '0;
    end else if (dma_type && cfg_ready) begin
      dma_type_reg <= cfg_data;
    end
  end

  assign adv = in_valid && (!m_tvalid || m_tready);

  scps_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .take     (adv),
    .valid    (in_valid),
    .op       (in_op),
    .item     (in_item)
  );

  scps_decide u_decide (
    .op       (in_op),
    .item     (in_item),
    .st       (st),
    .dma_type (dma_type_reg),
    .st_next  (st_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out <= res;
    end
  end

  assign m_tdata = {5'b00000,
                    out.bad_event,
                    out.done_res,
                    out.transferred_bytes,
                    out.wait_pack_empty,
                    out.drain_dma,
                    out.dma_to_memory,
                    out.select_target,
                    out.action,
                    out.command_status};

  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    adv && res.done_res |=> !st.busy)
    else $error("busy still set after a finishing word");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    adv && (in_op == OP_START) |=> st.busy && (st.cmd_status == 16'h0000))
    else $error("start word did not open a command");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("result register not loaded");

  a_drain_with_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out.drain_dma |-> out.wait_pack_empty &&
    (out.action == ACT_CMDCOMPLETE))
    else $error("drain without pack wait");

endmodule

`default_nettype wire
